@@ rtl/nfp_pkg.sv @@
// Package for the NMEA field parser: character codes, value limits and the
// result record shared by the parser logic. No dependencies.
`default_nettype none

package nfp_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharLowZ   = 8'h7A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  localparam int unsigned AddrChars = 5;
  localparam int unsigned AddrW     = 8 * AddrChars;

  localparam logic [3:0] FracLimitReset = 4'd5;
  localparam logic [3:0] FracLimitMax   = 4'd9;

  localparam logic [35:0] PosLimit = 36'h0_7FFF_FFFF;
  localparam logic [35:0] NegLimit = 36'h0_8000_0000;

  typedef struct packed {
    logic [AddrW-1:0]  sentence_address;
    logic [5:0]        field_number;
    logic signed [31:0] field_value;
    logic [3:0]        frac_digits;
    logic [7:0]        first_char;
    logic              is_numeric;
    logic              overflowed;
    logic              last_field;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/nmea_field_parser_top.sv @@
// NMEA-0183 sentence field parser, top level.
// Depends on nfp_pkg for character codes, limits and the result record.
`default_nettype none

// The parser takes one character per transaction and returns one result per
// closed field: the latched address, the field ordinal, the signed value with
// its kept fraction digits, the first byte and status flags. It sustains one
// character per clock cycle except while a field-closing character stalls.
// A character is held in an input register, where the accumulate-by-ten and
// flag update run, and the result lands in an output register; a character
// that closes a field waits in the input register only while the output
// register holds a result not yet taken.
module nmea_field_parser_top import nfp_pkg::*; #(
  parameter int unsigned MAX_FIELD = 63
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [3:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [7:0]         in_byte_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [AddrW-1:0]   sentence_address_o,
  output      logic [5:0]         field_number_o,
  output      logic signed [31:0] field_value_o,
  output      logic [3:0]         frac_digits_o,
  output      logic [7:0]         first_char_o,
  output      logic               is_numeric_o,
  output      logic               overflowed_o,
  output      logic               last_field_o
);

  logic [3:0] frac_lim_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;

  logic             in_sentence_q, in_sentence_d;
  logic [5:0]       field_count_q, field_count_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [2:0]       addr_len_q, addr_len_d;
  logic [31:0]      acc_q, acc_d;
  logic [3:0]       frac_q, frac_d;
  logic             neg_q, neg_d, dot_q, dot_d, bad_q, bad_d;
  logic             ovf_q, ovf_d, started_q, started_d;
  logic [7:0]       first_q, first_d;

  logic    out_valid_q;
  result_t res_q, res_d;

  logic [7:0]  b;
  logic        illegal, term, res_c, stall, proc;
  logic [3:0]  lim_frac;
  logic [35:0] acc_x10, limit;
  logic [31:0] mag;

  assign cfg_ready_o = 1'b1;
  assign b        = in_byte_q;
  assign illegal  = (b < CharSpace) || (b > CharLowZ);
  assign term     = (b == CharComma) || (b == CharStar) || illegal;
  assign res_c    = in_valid_q && in_sentence_q && (field_count_q != 6'd0) && term;
  assign stall    = res_c && out_valid_q && !out_ready_i;
  assign proc     = in_valid_q && !stall;
  assign in_ready_o = !in_valid_q || !stall;

  assign lim_frac = (frac_lim_q > FracLimitMax) ? FracLimitMax : frac_lim_q;
  assign acc_x10  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
                  + {32'd0, b[3:0] - CharZero[3:0]};
  assign limit    = neg_q ? NegLimit : PosLimit;

  always_comb begin
    in_sentence_d = in_sentence_q;
    field_count_d = field_count_q;
    addr_d        = addr_q;
    addr_len_d    = addr_len_q;
    acc_d         = acc_q;
    frac_d        = frac_q;
    neg_d         = neg_q;
    dot_d         = dot_q;
    bad_d         = bad_q;
    ovf_d         = ovf_q;
    started_d     = started_q;
    first_d       = first_q;

    mag = bad_q ? 32'd0 : acc_q;
    res_d.sentence_address = addr_q;
    res_d.field_number     = field_count_q;
    res_d.field_value      = neg_q ? -$signed(mag) : $signed(mag);
    res_d.frac_digits      = bad_q ? 4'd0 : frac_q;
    res_d.first_char       = started_q ? first_q : b;
    res_d.is_numeric       = !bad_q;
    res_d.overflowed       = !bad_q && ovf_q;
    res_d.last_field       = (b != CharComma);

    if (b == CharDollar) begin
      in_sentence_d = 1'b1;
      field_count_d = 6'd0;
      addr_d        = '0;
      addr_len_d    = 3'd0;
      acc_d = '0; frac_d = '0; first_d = '0;
      {neg_d, dot_d, bad_d, ovf_d, started_d} = '0;
    end else if (!in_sentence_q) begin
      // Bytes between sentences are dropped.
    end else if (field_count_q == 6'd0) begin
      if (b == CharComma) begin
        field_count_d = 6'd1;
        acc_d = '0; frac_d = '0; first_d = '0;
        {neg_d, dot_d, bad_d, ovf_d, started_d} = '0;
      end else if (term) begin
        in_sentence_d = 1'b0;
      end else if (addr_len_q < 3'(AddrChars)) begin
        for (int i = 0; i < AddrChars; i++) begin
          if (addr_len_q == 3'(AddrChars - 1 - i)) begin
            addr_d[i*8 +: 8] = b;
          end
        end
        addr_len_d = addr_len_q + 3'd1;
      end
    end else if (!term) begin
      started_d = 1'b1;
      if (!started_q) begin
        first_d = b;
      end
      if (!bad_q) begin
        if (b == CharMinus) begin
          if (!started_q) neg_d = 1'b1;
          else            bad_d = 1'b1;
        end else if (b == CharDot) begin
          if (dot_q) bad_d = 1'b1;
          else       dot_d = 1'b1;
        end else if (b >= CharZero && b <= CharNine) begin
          // Fraction digits beyond the limit are skipped entirely.
          if (!(dot_q && frac_q >= lim_frac)) begin
            if (dot_q) begin
              frac_d = frac_q + 4'd1;
            end
            if (!ovf_q) begin
              if (acc_x10 > limit) begin
                acc_d = limit[31:0];
                ovf_d = 1'b1;
              end else begin
                acc_d = acc_x10[31:0];
              end
            end
          end
        end else begin
          bad_d = 1'b1;
        end
      end
    end else begin
      if (b != CharComma) begin
        in_sentence_d = 1'b0;
      end else if (field_count_q < 6'(MAX_FIELD)) begin
        field_count_d = field_count_q + 6'd1;
      end
      acc_d = '0; frac_d = '0; first_d = '0;
      {neg_d, dot_d, bad_d, ovf_d, started_d} = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_lim_q    <= FracLimitReset;
      in_valid_q    <= 1'b0;
      in_sentence_q <= 1'b0;
      field_count_q <= '0;
      addr_q        <= '0;
      addr_len_q    <= '0;
      acc_q         <= '0;
      frac_q        <= '0;
      neg_q         <= 1'b0;
      dot_q         <= 1'b0;
      bad_q         <= 1'b0;
      ovf_q         <= 1'b0;
      started_q     <= 1'b0;
      first_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        frac_lim_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc) begin
        in_sentence_q <= in_sentence_d;
        field_count_q <= field_count_d;
        addr_q        <= addr_d;
        addr_len_q    <= addr_len_d;
        acc_q         <= acc_d;
        frac_q        <= frac_d;
        neg_q         <= neg_d;
        dot_q         <= dot_d;
        bad_q         <= bad_d;
        ovf_q         <= ovf_d;
        started_q     <= started_d;
        first_q       <= first_d;
      end
      if (proc && res_c) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
    if (proc && res_c) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sentence_address_o = res_q.sentence_address;
  assign field_number_o     = res_q.field_number;
  assign field_value_o      = res_q.field_value;
  assign frac_digits_o      = res_q.frac_digits;
  assign first_char_o       = res_q.first_char;
  assign is_numeric_o       = res_q.is_numeric;
  assign overflowed_o       = res_q.overflowed;
  assign last_field_o       = res_q.last_field;

  // The field ordinal never passes its ceiling.
  a_field_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_count_q <= 6'(MAX_FIELD))
    else $error("field count above its ceiling");

  // A result always belongs to a field after the address.
  a_field_number_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_number_o != 6'd0)
    else $error("result with field number zero");

  // A non-numeric field reports a zero value and no overflow or fraction.
  a_nonnumeric_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_numeric_o) |->
      (field_value_o == 32'sd0 && !overflowed_o && frac_digits_o == 4'd0))
    else $error("non-numeric field carries a value");

  // Kept fraction digits never exceed nine.
  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= FracLimitMax)
    else $error("fraction count above nine");

  // A terminator held back by a full output stage is not lost.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled terminator dropped");

endmodule

`default_nettype wire
